// ===== src/mbcrc_pkg.sv =====
// mbcrc_pkg: types, status codes and the crc-16 byte update for the
// modbus response crc check block
// no dependencies
package mbcrc_pkg;

    localparam int CNT_W = 8;
    localparam int CAP_DEPTH = 8;
    localparam int CAP_FIRST = 3;
    localparam int CAP_LAST = 10;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_ZERO = 16'h0000;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_BAD_CRC = 2'd2;
    localparam logic [1:0] ST_SHORT = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] value_a;
        logic [15:0] value_b;
        logic [15:0] value_c;
        logic [15:0] value_d;
    } t_result;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== src/modbus_response_crc_check.sv =====
// modbus_response_crc_check: top level with input word register, result
// register and mode register
// depends on mbcrc_pkg and mbcrc_frame
//
// usage
// - input channel: one frame byte per word on i_frame_byte, i_last_byte high
//   on the final byte of a modbus rtu response (trailing two bytes are crc)
// - output channel: one word per frame on the last byte: o_status and the
//   big-endian register values o_value_a..o_value_d
// - i_cfg_we / i_cfg_wdata write the four-value mode bit; write only when idle
// - result path: the last byte is held in the input register, then moves
//   into the result register, which raises o_out_valid
// - throughput: one byte per cycle while no final byte waits; the byte-wide
//   crc update sits between the input register and the frame state
// - reset (synchronous, active low) empties both registers, restarts the
//   frame and clears the mode bit
// - when the receiver stalls with a result waiting, non-final bytes keep
//   flowing; only a final byte waits in the input register until the result
//   register frees
module modbus_response_crc_check #(
    parameter int MAX_FRAME_BYTES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_value_a,
    output logic [15:0] o_value_b,
    output logic [15:0] o_value_c,
    output logic [15:0] o_value_d,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata
);

    localparam logic [7:0] MaxCnt = 8'(MAX_FRAME_BYTES);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_last;
    logic               r_mode;
    logic               r_out_valid;
    mbcrc_pkg::t_result r_out;
    mbcrc_pkg::t_result result;
    logic               out_free;
    logic               consume;

    assign out_free = !r_out_valid || i_out_ready;
    assign consume = r_in_valid && (!r_in_last || out_free);
    assign o_in_ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_frame_byte;
            r_in_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    mbcrc_frame #(
        .MAX_CNT (MaxCnt)
    ) u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_consume (consume),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .i_mode    (r_mode),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && r_in_last) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status = r_out.status;
    assign o_value_a = r_out.value_a;
    assign o_value_b = r_out.value_b;
    assign o_value_c = r_out.value_c;
    assign o_value_d = r_out.value_d;

`ifndef NO_ASSERTIONS
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume && r_in_last |=> o_out_valid)
        else $error("final byte consumed without a result");

    a_error_zero_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != mbcrc_pkg::ST_OK |->
            o_value_a == 16'h0000 && o_value_b == 16'h0000
            && o_value_c == 16'h0000 && o_value_d == 16'h0000)
        else $error("values not cleared on error status");

    a_stall_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid && r_in_last && o_out_valid && !i_out_ready)
        else $error("input stalled without a blocked final byte");
`endif

endmodule

// ===== src/mbcrc_frame.sv =====
// mbcrc_frame: per-frame state (running crc, two-byte hold, count, capture)
// and the end-of-frame result logic
// depends on mbcrc_pkg
module mbcrc_frame #(
    parameter logic [7:0] MAX_CNT = 8'd128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_consume,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    input  logic                 i_mode,
    output mbcrc_pkg::t_result   o_result
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [7:0]  r_held [2];
    logic [mbcrc_pkg::CNT_W-1:0] r_count;
    logic [7:0]  r_cap [mbcrc_pkg::CAP_DEPTH];
    logic [7:0]  n_cap [mbcrc_pkg::CAP_DEPTH];
    logic        cap_en;
    logic [2:0]  cap_off;
    logic [15:0] rx_crc;
    logic [1:0]  status;

    assign n_crc = (r_count >= 8'd2) ? mbcrc_pkg::crc_feed(r_crc, r_held[0]) : r_crc;
    assign cap_en = (r_count < MAX_CNT) && (r_count >= 8'(mbcrc_pkg::CAP_FIRST))
                    && (r_count <= 8'(mbcrc_pkg::CAP_LAST));
    assign cap_off = r_count[2:0] - 3'(mbcrc_pkg::CAP_FIRST);
    assign rx_crc = {i_byte, r_held[1]};

    always_comb begin
        for (int j = 0; j < mbcrc_pkg::CAP_DEPTH; j++) begin
            n_cap[j] = r_cap[j];
        end
        if (cap_en) begin
            n_cap[cap_off] = i_byte;
        end
    end

    always_comb begin
        if (r_count < 8'd2) begin
            status = mbcrc_pkg::ST_SHORT;
        end else if (rx_crc == mbcrc_pkg::CRC_ZERO || rx_crc == mbcrc_pkg::CRC_INIT) begin
            status = mbcrc_pkg::ST_BAD_CRC;
        end else if (rx_crc != n_crc) begin
            status = mbcrc_pkg::ST_MISMATCH;
        end else begin
            status = mbcrc_pkg::ST_OK;
        end
    end

    always_comb begin
        o_result = '0;
        o_result.status = status;
        if (status == mbcrc_pkg::ST_OK) begin
            o_result.value_a = {n_cap[0], n_cap[1]};
            if (i_mode) begin
                o_result.value_b = {n_cap[2], n_cap[3]};
                o_result.value_c = {n_cap[4], n_cap[5]};
                o_result.value_d = {n_cap[6], n_cap[7]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_consume && i_last)) begin
            r_crc <= mbcrc_pkg::CRC_INIT;
            r_held[0] <= '0;
            r_held[1] <= '0;
            r_count <= '0;
            for (int j = 0; j < mbcrc_pkg::CAP_DEPTH; j++) begin
                r_cap[j] <= '0;
            end
        end else if (i_consume) begin
            r_crc <= n_crc;
            r_held[0] <= r_held[1];
            r_held[1] <= i_byte;
            if (r_count < MAX_CNT) begin
                r_count <= r_count + 8'd1;
            end
            for (int j = 0; j < mbcrc_pkg::CAP_DEPTH; j++) begin
                r_cap[j] <= n_cap[j];
            end
        end
    end

endmodule

// ===== tb/tb.sv =====
// tb: self-checking testbench for modbus_response_crc_check, frames of random
// content pushed through the valid/ready channels and checked against a predictor
// depends on mbcrc_pkg and the modbus_response_crc_check rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BYTES = 128;
    localparam int HOLD_CYCLES = 200;
    localparam int MAX_REPORTS = 10;

    typedef enum {FR_GOOD, FR_MISMATCH, FR_CRC_ZERO, FR_CRC_ONES, FR_RAW} t_frame_kind;

    class response_tracker;
        int                 max_bytes;
        bit                 mode;
        logic [15:0]        crc;
        logic [7:0]         held [2];
        int                 count;
        logic [7:0]         captured [mbcrc_pkg::CAP_DEPTH];
        mbcrc_pkg::t_result expected_responses [$];
        int                 mismatches;
        int                 checked;
        int                 frames;
        int                 status_seen [4];

        function new(int max_bytes);
            this.max_bytes = max_bytes;
            mode = 1'b0;
            mismatches = 0;
            checked = 0;
            frames = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            restart();
        endfunction

        static function logic [15:0] crc16_update(logic [15:0] c, logic [7:0] d);
            logic [15:0] r;
            r = c;
            for (int i = 0; i < 8; i++) begin
                if (r[0] ^ d[i]) begin
                    r = (r >> 1) ^ mbcrc_pkg::CRC_POLY;
                end else begin
                    r = r >> 1;
                end
            end
            return r;
        endfunction

        function void restart();
            crc = mbcrc_pkg::CRC_INIT;
            held[0] = 8'h00;
            held[1] = 8'h00;
            count = 0;
            foreach (captured[i]) captured[i] = 8'h00;
        endfunction

        function void take_byte(logic [7:0] b, logic last);
            logic [7:0]         prev;
            int                 c;
            logic [15:0]        rx;
            mbcrc_pkg::t_result r;
            prev = held[1];
            c = count;
            if (c >= 2) crc = crc16_update(crc, held[0]);
            held[0] = held[1];
            held[1] = b;
            if (c < max_bytes) begin
                if (c >= mbcrc_pkg::CAP_FIRST && c <= mbcrc_pkg::CAP_LAST) begin
                    captured[c - mbcrc_pkg::CAP_FIRST] = b;
                end
                count = c + 1;
            end
            if (!last) return;
            rx = {b, prev};
            r = '0;
            if (c < 2) begin
                r.status = mbcrc_pkg::ST_SHORT;
            end else if (rx == mbcrc_pkg::CRC_ZERO || rx == ~mbcrc_pkg::CRC_ZERO) begin
                r.status = mbcrc_pkg::ST_BAD_CRC;
            end else if (rx != crc) begin
                r.status = mbcrc_pkg::ST_MISMATCH;
            end else begin
                r.status = mbcrc_pkg::ST_OK;
            end
            if (r.status == mbcrc_pkg::ST_OK) begin
                r.value_a = {captured[0], captured[1]};
                if (mode) begin
                    r.value_b = {captured[2], captured[3]};
                    r.value_c = {captured[4], captured[5]};
                    r.value_d = {captured[6], captured[7]};
                end
            end
            expected_responses.push_back(r);
            frames++;
            restart();
        endfunction

        function void report(string what, mbcrc_pkg::t_result e, mbcrc_pkg::t_result g);
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%s: expected status %0d a %h b %h c %h d %h, ",
                         what, e.status, e.value_a, e.value_b, e.value_c, e.value_d,
                         "got status %0d a %h b %h c %h d %h",
                         g.status, g.value_a, g.value_b, g.value_c, g.value_d);
            end
        endfunction

        function void check_response(mbcrc_pkg::t_result got);
            mbcrc_pkg::t_result e;
            bit                 bad;
            if (expected_responses.size() == 0) begin
                report("response with none pending", '0, got);
                return;
            end
            e = expected_responses.pop_front();
            checked++;
            status_seen[e.status]++;
            bad = 1'b0;
            if (got.status !== e.status) bad = 1'b1;
            if (got.value_a !== e.value_a) bad = 1'b1;
            if (got.value_b !== e.value_b) bad = 1'b1;
            if (got.value_c !== e.value_c) bad = 1'b1;
            if (got.value_d !== e.value_d) bad = 1'b1;
            if (bad) report("response mismatch", e, got);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_frame_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [15:0] o_value_a;
    logic [15:0] o_value_b;
    logic [15:0] o_value_c;
    logic [15:0] o_value_d;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;

    response_tracker sb = new(MAX_BYTES);
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit idle_fixed = 1'b0;
    bit hold_req = 1'b0;
    int bytes_sent = 0;
    bit modes_seen [2] = '{1'b0, 1'b0};

    modbus_response_crc_check #(
        .MAX_FRAME_BYTES(MAX_BYTES)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_frame_byte(i_frame_byte),
        .i_last_byte (i_last_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_value_a   (o_value_a),
        .o_value_b   (o_value_b),
        .o_value_c   (o_value_c),
        .o_value_d   (o_value_d),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.take_byte(i_frame_byte, i_last_byte);
            if (o_out_valid && i_out_ready) begin
                sb.check_response({o_status, o_value_a, o_value_b, o_value_c, o_value_d});
            end
        end
    end

    // receiver: random stall bursts plus one long hold-off on request
    initial begin
        int hold_left;
        int gap_left;
        hold_left = 0;
        gap_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                i_out_ready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                gap_left = $urandom_range(1, 13) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic send_word(input logic [7:0] b, input logic last);
        if (tx_idle_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_frame_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input t_frame_kind kind, input int len, input int fill);
        logic [7:0]  body [$];
        logic [15:0] c;
        int          n;
        n = (kind == FR_RAW) ? len : len - 2;
        c = mbcrc_pkg::CRC_INIT;
        for (int i = 0; i < n; i++) begin
            if (fill < 0) begin
                body.push_back(8'($urandom_range(0, 255)));
            end else begin
                body.push_back(8'(fill));
            end
            c = response_tracker::crc16_update(c, body[i]);
        end
        case (kind)
            FR_MISMATCH: c = c ^ 16'($urandom_range(1, 65535));
            FR_CRC_ZERO: c = mbcrc_pkg::CRC_ZERO;
            FR_CRC_ONES: c = ~mbcrc_pkg::CRC_ZERO;
            default: ;
        endcase
        if (kind != FR_RAW) begin
            body.push_back(c[7:0]);
            body.push_back(c[15:8]);
        end
        foreach (body[i]) send_word(body[i], i == body.size() - 1);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.expected_responses.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_mode(input bit m);
        wait_drained();
        repeat (4) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        sb.mode = m;
        modes_seen[m] = 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_frame();
        t_frame_kind kind;
        int          len;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 85) len = $urandom_range(3, 14);
        else if (r < 95) len = $urandom_range(15, 40);
        else if (r < 98) len = $urandom_range(1, 2);
        else len = $urandom_range(MAX_BYTES + 1, MAX_BYTES + 12);
        r = $urandom_range(0, 99);
        if (r < 70) kind = FR_GOOD;
        else if (r < 80) kind = FR_MISMATCH;
        else if (r < 84) kind = FR_CRC_ZERO;
        else if (r < 88) kind = FR_CRC_ONES;
        else kind = FR_RAW;
        if (len < 3) kind = FR_RAW;
        send_frame(kind, len, -1);
    endtask

    task automatic random_phase(input bit m, input int nbytes, input bit pause_mid);
        int start;
        int nframes;
        bit paused;
        write_mode(m);
        start = bytes_sent;
        nframes = 0;
        paused = 1'b0;
        while (bytes_sent - start < nbytes) begin
            if (!idle_fixed && nframes % 20 == 0) begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            if (pause_mid && !paused && bytes_sent - start >= nbytes / 2) begin
                paused = 1'b1;
                wait_drained();
            end
            random_frame();
            nframes++;
        end
    endtask

    initial begin
        int fails;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: short frames, bad crc values, full capture of all-ones bytes
        write_mode(1'b1);
        send_frame(FR_RAW, 1, 8'hFF);
        send_frame(FR_RAW, 2, 8'h00);
        send_frame(FR_MISMATCH, 4, -1);
        send_frame(FR_GOOD, 13, 8'hFF);
        send_frame(FR_CRC_ZERO, 3, -1);
        send_frame(FR_CRC_ONES, 3, -1);

        // long receiver hold-off while short frames keep coming
        write_mode(1'b0);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_req = 1'b1;
        repeat (6) send_frame(FR_GOOD, $urandom_range(3, 5), -1);

        random_phase(1'b0, 400, 1'b0);
        random_phase(1'b1, 420, 1'b1);
        random_phase(1'b0, 420, 1'b0);
        wait_drained();
        idle_fixed = 1'b1;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        random_phase(1'b1, 420, 1'b0);

        wait_drained();
        repeat (8) @(negedge i_clk);
        fails = sb.mismatches + sb.expected_responses.size();
        $display("covered %0d frames / %0d bytes in modes %0d and %0d, incl. saturated lengths",
                 sb.frames, bytes_sent, !modes_seen[0], modes_seen[1]);
        $display("checked %0d responses: ok %0d, crc mismatch %0d, ",
                 sb.checked, sb.status_seen[mbcrc_pkg::ST_OK],
                 sb.status_seen[mbcrc_pkg::ST_MISMATCH],
                 "bad crc %0d, short %0d; %0d errors",
                 sb.status_seen[mbcrc_pkg::ST_BAD_CRC],
                 sb.status_seen[mbcrc_pkg::ST_SHORT], fails);
        if (fails == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
